// ===== rtl/permutation_combination_count_macros.svh =====
// assertion macros for the permutation and combination counter
`ifndef PERMUTATION_COMBINATION_COUNT_MACROS_SVH
`define PERMUTATION_COMBINATION_COUNT_MACROS_SVH
`ifndef SYNTHESIS
`define PCC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcc assertion failed");
`define PCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcc assertion failed");
`else
`define PCC_ASSERT_SAME(lbl, ante, cons)
`define PCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/pcc_pkg.sv =====
// shared types and constants for the permutation and combination counter
package pcc_pkg;

	localparam int FACTOR_W = 16;

	typedef struct packed {
		logic init;
		logic step;
	} mul_ctl_t;

endpackage

// ===== rtl/pcc_mul.sv =====
// shared multiply unit with running product and overflow detect
module pcc_mul #(
	parameter int AccW = 63
) (
	input  logic                          clk,
	input  pcc_pkg::mul_ctl_t             ctl,
	input  logic [pcc_pkg::FACTOR_W-1:0]  factor,
	output logic [AccW-1:0]               acc,
	output logic                          ovf
);

	localparam int ProdW = AccW + pcc_pkg::FACTOR_W;

	logic [ProdW-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			prod_q <= ProdW'(1);
		end else if (ctl.step) begin
			prod_q <= ProdW'(prod_q[AccW-1:0]) * ProdW'(factor);
		end
	end

	assign acc = prod_q[AccW-1:0];
	// past the signed limit when any bit above the value range is set
	assign ovf = |prod_q[ProdW-1:AccW];

endmodule

// ===== rtl/pcc_div.sv =====
// restoring divider, one quotient bit per cycle
module pcc_div #(
	parameter int AccW = 63
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [AccW-1:0] dividend,
	input  logic [AccW-1:0] divisor,
	output logic [AccW-1:0] quotient,
	output logic            done
);

	localparam int CntW = $clog2(AccW + 1);

	logic [AccW-1:0] rem_q;
	logic [AccW-1:0] quo_q;
	logic [CntW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [AccW:0]   shifted;
	logic [AccW:0]   diff;
	logic            ge;
	logic [AccW-1:0] rem_next;

	always_comb begin
		shifted  = {rem_q, quo_q[AccW-1]};
		diff     = shifted - {1'b0, divisor};
		ge       = !diff[AccW];
		rem_next = ge ? diff[AccW-1:0] : shifted[AccW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(AccW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[AccW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== rtl/permutation_combination_count.sv =====
// top level: sequencer for permutation and combination counts
// One request at a time. A bad request (k = 0 or k > n) gives its result in the
// next cycle. Otherwise the falling product takes one multiply per cycle on the
// shared multiplier for P(n,k); C(n,k) then forms k! on the same multiplier
// and divides in the restoring divider (one quotient bit a cycle), after
// which the quotient is registered as the result. Overflow stops the work
// at the first product past the signed limit. The result is shown for one
// cycle with done high and cannot be held off; busy is low again in that
// same cycle.
module permutation_combination_count #(
	parameter int RESULT_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [15:0] set_size,
	input  logic [15:0] pick_count,
	output logic        done,
	output logic [62:0] count_value,
	output logic        overflow,
	output logic        bad_request
);

	`include "permutation_combination_count_macros.svh"

	localparam int AccW   = RESULT_BITS - 1;
	localparam int CountW = 63;
	localparam int FW     = pcc_pkg::FACTOR_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PERM = 4'b0010,
		S_FACT = 4'b0100,
		S_DIV  = 4'b1000
	} state_t;

	state_t            state_q;
	logic              op_q;
	logic [FW-1:0]     f_q;
	logic [FW-1:0]     cnt_q;
	logic [FW-1:0]     k_q;
	logic [AccW-1:0]   perm_q;
	logic              done_q;
	logic [CountW-1:0] value_q;
	logic              ovf_q;
	logic              bad_q;

	pcc_pkg::mul_ctl_t mul_ctl;
	logic [AccW-1:0]   mul_acc;
	logic              mul_ovf;
	logic              div_start;
	logic [AccW-1:0]   div_quo;
	logic              div_done;
	logic              accept;
	logic              good;
	logic              cnt_zero;

	assign accept   = start && (state_q == S_IDLE);
	assign good     = (pick_count != 16'd0) && (pick_count <= set_size);
	assign cnt_zero = (cnt_q == '0);

	always_comb begin
		mul_ctl.init = (accept && good)
			|| ((state_q == S_PERM) && !mul_ovf && cnt_zero && op_q);
		mul_ctl.step = ((state_q == S_PERM) || (state_q == S_FACT)) && !mul_ovf && !cnt_zero;
		div_start    = (state_q == S_FACT) && !mul_ovf && cnt_zero;
	end

	pcc_mul #(.AccW(AccW)) u_mul (
		.clk    (clk),
		.ctl    (mul_ctl),
		.factor (f_q),
		.acc    (mul_acc),
		.ovf    (mul_ovf)
	);

	pcc_div #(.AccW(AccW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (perm_q),
		.divisor  (mul_acc),
		.quotient (div_quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			value_q <= '0;
			ovf_q   <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (good) begin
							state_q <= S_PERM;
						end else begin
							done_q  <= 1'b1;
							value_q <= '0;
							ovf_q   <= 1'b0;
							bad_q   <= 1'b1;
						end
					end
				end
				S_PERM: begin
					if (mul_ovf) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						value_q <= '0;
						ovf_q   <= 1'b1;
						bad_q   <= 1'b0;
					end else if (cnt_zero) begin
						if (op_q) begin
							state_q <= S_FACT;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
							value_q <= CountW'(mul_acc);
							ovf_q   <= 1'b0;
							bad_q   <= 1'b0;
						end
					end
				end
				S_FACT: begin
					if (mul_ovf) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						value_q <= '0;
						ovf_q   <= 1'b1;
						bad_q   <= 1'b0;
					end else if (cnt_zero) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						value_q <= CountW'(div_quo);
						ovf_q   <= 1'b0;
						bad_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// factor and count registers for the two falling products
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			f_q   <= set_size;
			cnt_q <= pick_count;
			k_q   <= pick_count;
		end else if (mul_ctl.init) begin
			perm_q <= mul_acc;
			f_q    <= k_q;
			cnt_q  <= k_q;
		end else if (mul_ctl.step) begin
			f_q   <= f_q - FW'(1);
			cnt_q <= cnt_q - FW'(1);
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign count_value = value_q;
	assign overflow    = ovf_q;
	assign bad_request = bad_q;

	`PCC_ASSERT_SAME(a_flags_excl, done, !(overflow && bad_request))
	`PCC_ASSERT_SAME(a_zero_on_flag, done && (overflow || bad_request), count_value == '0)
	`PCC_ASSERT_NEXT(a_bad_next, accept && !good, done && bad_request && !busy)
	`PCC_ASSERT_SAME(a_div_only_comb, state_q == S_DIV, op_q)

endmodule
